@@ design/numeric_literal_scanner_macros.svh @@
// Assertion macros used by the scanner's top-level RTL file.
`ifndef NUMERIC_LITERAL_SCANNER_MACROS_SVH
`define NUMERIC_LITERAL_SCANNER_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define NLS_ASSERT_SAME(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition a implies condition c in the next cycle.
`define NLS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

@@ design/nls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_pkg
// Types, codes and character constants of the numeric literal scanner.
// ----------------------------------------------------------------------------
package nls_pkg;

  localparam logic [7:0] MAX_LENGTH = 8'd255;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOLIT   = 3'd1,
    ST_PREFIX  = 3'd2,
    ST_DUPPT   = 3'd3,
    ST_BADDIG  = 3'd4,
    ST_MISSING = 3'd5,
    ST_OVF     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ZERO,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic       start_req;
    logic       has_char;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_float;
    logic [63:0] int_value;
    logic [63:0] frac_value;
    logic [7:0]  frac_digits;
    logic [1:0]  radix;
    logic [7:0]  raw_length;
  } result_t;

endpackage

@@ design/nls_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_stream_if
// Valid/ready channels for source characters and literal results.
// ----------------------------------------------------------------------------
interface nls_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       has_char;
  logic [7:0] ch;

  modport source (output valid, output start_req, output has_char, output ch, input ready);
  modport sink   (input valid, input start_req, input has_char, input ch, output ready);
endinterface

interface nls_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_float;
  logic [63:0] int_value;
  logic [63:0] frac_value;
  logic [7:0]  frac_digits;
  logic [1:0]  radix;
  logic [7:0]  raw_length;

  modport source (output valid, output status, output is_float, output int_value,
                  output frac_value, output frac_digits, output radix,
                  output raw_length, input ready);
  modport sink   (input valid, input status, input is_float, input int_value,
                  input frac_value, input frac_digits, input radix,
                  input raw_length, output ready);
endinterface

@@ design/nls_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_core
// Literal state and the per-character scan step: decode, shift-add by the
// base, and result formation.
// ----------------------------------------------------------------------------
module nls_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  nls_pkg::item_t   item,
  output logic             emit,
  output nls_pkg::result_t result
);
  import nls_pkg::*;

  phase_t      phase;
  logic [1:0]  radix_code;
  logic [63:0] int_acc;
  logic [63:0] frac_acc;
  logic [7:0]  frac_count;
  logic        point_seen;
  logic        digit_seen;
  logic [7:0]  char_count;
  logic        overflowed;

  phase_t      w_ph;
  logic [1:0]  w_rc;
  logic [63:0] w_ia;
  logic [63:0] w_fa;
  logic [7:0]  w_fc;
  logic        w_ps;
  logic        w_ds;
  logic [7:0]  w_cc;
  logic        w_ov;
  status_t     st;
  logic        do_body;

  logic        is_dig;
  logic        is_alpha;
  logic [4:0]  dval;
  logic [4:0]  base;
  logic        dig_ok;
  logic [7:0]  cc_inc;
  logic [64:0] int_ma;
  logic [64:0] frac_ma;

  // Returns {overflow, value} of acc * base + d, saturating to all ones.
  function automatic logic [64:0] mul_add(input logic [63:0] acc, input logic [1:0] rc,
                                          input logic [3:0] d);
    logic [68:0] p;
    logic        ovf;
    case (rc)
      RADIX_BIN: p = {4'b0, acc, 1'b0};
      RADIX_OCT: p = {2'b0, acc, 3'b0};
      RADIX_HEX: p = {1'b0, acc, 4'b0};
      default:   p = {2'b0, acc, 3'b0} + {4'b0, acc, 1'b0};
    endcase
    p   = p + {65'b0, d};
    ovf = |p[68:64];
    return {ovf, ovf ? {64{1'b1}} : p[63:0]};
  endfunction

  always_comb begin
    is_dig   = item.ch inside {[CH_ZERO:CH_NINE]};
    is_alpha = item.ch inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    if (is_dig) begin
      dval = {1'b0, 4'(item.ch - CH_ZERO)};
    end else if (item.ch inside {[8'h61:8'h66]}) begin
      dval = {1'b0, 4'(item.ch - 8'h57)};
    end else if (item.ch inside {[8'h41:8'h46]}) begin
      dval = {1'b0, 4'(item.ch - 8'h37)};
    end else begin
      dval = 5'd16;
    end
    case (radix_code)
      RADIX_BIN: base = 5'd2;
      RADIX_OCT: base = 5'd8;
      RADIX_DEC: base = 5'd10;
      default:   base = 5'd16;
    endcase
  end

  assign dig_ok  = dval < base;
  assign cc_inc  = (char_count < MAX_LENGTH) ? char_count + 8'd1 : char_count;
  assign int_ma  = mul_add(int_acc, radix_code, dval[3:0]);
  assign frac_ma = mul_add(frac_acc, radix_code, dval[3:0]);

  // Scan step: working copy of the literal state as it stands after this
  // character, before an emitted result clears it.
  always_comb begin
    w_ph    = phase;
    w_rc    = radix_code;
    w_ia    = int_acc;
    w_fa    = frac_acc;
    w_fc    = frac_count;
    w_ps    = point_seen;
    w_ds    = digit_seen;
    w_cc    = char_count;
    w_ov    = overflowed;
    emit    = 1'b0;
    st      = ST_OK;
    do_body = 1'b0;

    if (item.start_req) begin
      w_ph = PH_IDLE;
      w_rc = RADIX_DEC;
      w_ia = '0;
      w_fa = '0;
      w_fc = '0;
      w_ps = 1'b0;
      w_ds = 1'b0;
      w_cc = '0;
      w_ov = 1'b0;
      if (!item.has_char || !is_dig) begin
        emit = 1'b1;
        st   = ST_NOLIT;
      end else begin
        w_cc = 8'd1;
        if (item.ch == CH_ZERO) begin
          w_ph = PH_ZERO;
        end else begin
          w_ph = PH_BODY;
          w_ds = 1'b1;
          w_ia = {60'b0, dval[3:0]};
        end
      end
    end else if (phase == PH_ZERO) begin
      if (item.has_char && is_alpha) begin
        w_cc = cc_inc;
        w_ph = PH_BODY;
        case (item.ch)
          CH_B:    w_rc = RADIX_BIN;
          CH_O:    w_rc = RADIX_OCT;
          CH_D:    w_rc = RADIX_DEC;
          CH_X:    w_rc = RADIX_HEX;
          default: begin
            emit = 1'b1;
            st   = ST_PREFIX;
          end
        endcase
      end else begin
        // A lone zero is a decimal digit; this character belongs to the body.
        w_ph    = PH_BODY;
        w_ds    = 1'b1;
        do_body = 1'b1;
      end
    end else if (phase == PH_BODY) begin
      do_body = 1'b1;
    end

    if (do_body) begin
      if (item.has_char && dig_ok) begin
        w_cc = cc_inc;
        w_ds = 1'b1;
        if (point_seen) begin
          w_fa = frac_ma[63:0];
          if (frac_ma[64] || frac_count == 8'd255) begin
            w_ov = 1'b1;
          end
          if (frac_count != 8'd255) begin
            w_fc = frac_count + 8'd1;
          end
        end else begin
          w_ia = int_ma[63:0];
          if (int_ma[64]) begin
            w_ov = 1'b1;
          end
        end
      end else if (item.has_char && item.ch == CH_UNDER) begin
        w_cc = cc_inc;
      end else if (item.has_char && item.ch == CH_POINT) begin
        w_cc = cc_inc;
        if (point_seen) begin
          emit = 1'b1;
          st   = ST_DUPPT;
        end else begin
          w_ps = 1'b1;
        end
      end else if (item.has_char && (is_alpha || is_dig)) begin
        w_cc = cc_inc;
        emit = 1'b1;
        st   = ST_BADDIG;
      end else begin
        // End of source or a delimiter; the delimiter is not counted in the literal.
        emit = 1'b1;
        if (!w_ds) begin
          st = ST_MISSING;
        end else if (w_ov) begin
          st = ST_OVF;
        end else begin
          st = ST_OK;
        end
      end
    end
  end

  always_comb begin
    result.status      = st;
    result.is_float    = w_ps;
    result.int_value   = w_ia;
    result.frac_value  = w_fa;
    result.frac_digits = w_fc;
    result.radix       = w_rc;
    result.raw_length  = w_cc;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && emit)) begin
      phase      <= PH_IDLE;
      radix_code <= RADIX_DEC;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
      point_seen <= 1'b0;
      digit_seen <= 1'b0;
      char_count <= '0;
      overflowed <= 1'b0;
    end else if (step) begin
      phase      <= w_ph;
      radix_code <= w_rc;
      int_acc    <= w_ia;
      frac_acc   <= w_fa;
      frac_count <= w_fc;
      point_seen <= w_ps;
      digit_seen <= w_ds;
      char_count <= w_cc;
      overflowed <= w_ov;
    end
  end

endmodule

@@ design/numeric_literal_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Prefixed-radix numeric literal scanner, one source character per transaction.
// ----------------------------------------------------------------------------
// The scanner can take one character transaction every clock cycle while no
// result waits in the result register. A character is held in the input
// register, and the scan step that follows it (character decode plus one
// shift-add of each accumulator by the base) is combinational. When the
// character ends a literal, its result is loaded into the result register
// when the scan step advances, and is presented from there until it is
// taken. Throughput is one character per cycle as long as the result side
// keeps up. While a result waits in the result register, the character in
// the input register is held as well, whether or not it ends a literal, so
// input stalls until the waiting result is taken.
module numeric_literal_scanner (
  input logic       clk,
  input logic       rst,
  nls_in_if.sink    chars,
  nls_out_if.source results
);
  import nls_pkg::*;
  `include "numeric_literal_scanner_macros.svh"

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_data;
  logic    advance;
  logic    emit;
  result_t result;

  // The registered character moves through the scan step when the result
  // register is free or is being emptied in this cycle.
  assign advance     = in_valid && (!out_valid || results.ready);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_item.start_req <= chars.start_req;
      in_item.has_char  <= chars.has_char;
      in_item.ch        <= chars.ch;
    end
  end

  nls_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (results.valid && results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= result;
    end
  end

  assign results.valid       = out_valid;
  assign results.status      = out_data.status;
  assign results.is_float    = out_data.is_float;
  assign results.int_value   = out_data.int_value;
  assign results.frac_value  = out_data.frac_value;
  assign results.frac_digits = out_data.frac_digits;
  assign results.radix       = out_data.radix;
  assign results.raw_length  = out_data.raw_length;

  `NLS_ASSERT_SAME(a_stall_cause, clk, rst, in_valid && !chars.ready, out_valid && !results.ready, "input stalled while the result register could take a result")
  `NLS_ASSERT_NEXT(a_result_loaded, clk, rst, advance && emit, out_valid, "emitted result did not reach the result register")
  `NLS_ASSERT_SAME(a_nolit_empty, clk, rst, out_valid && out_data.status == ST_NOLIT, out_data.raw_length == 8'd0 && out_data.int_value == 64'd0 && out_data.radix == RADIX_DEC, "no-literal result carries data")
  `NLS_ASSERT_SAME(a_prefix_len, clk, rst, out_valid && out_data.status == ST_PREFIX, out_data.raw_length == 8'd2 && !out_data.is_float, "bad prefix result has wrong length")

endmodule
